[sv/lacr_pkg.sv]
package lacr_pkg;

    // Register map, index = paddr[3:2]
    localparam logic [1:0] REG_FAMILY = 2'd0;
    localparam logic [1:0] REG_PORT   = 2'd1;
    localparam logic [1:0] REG_LIMIT  = 2'd2;
    localparam logic [1:0] REG_ONLY   = 2'd3;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Stream word widths
    localparam int IN_DATA_W  = 200;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 176;
    localparam int OUT_USER_W = 1;

    // addr_kind codes
    localparam logic [1:0] KIND_V4 = 2'd1;
    localparam logic [1:0] KIND_V6 = 2'd2;

    localparam logic [31:0] FLAG_TEMPORARY = 32'h0000_0001;
    localparam logic [31:0] FLAG_BAD       = 32'h0000_0068; // dad failed, deprecated, tentative

    localparam logic [2:0] RANK_PUBLIC  = 3'd0;
    localparam logic [2:0] RANK_PRIVATE = 3'd1;
    localparam logic [2:0] RANK_ULA     = 3'd2;
    localparam logic [2:0] RANK_NONE    = 3'd7;

    localparam logic [5:0] LIMIT_MAX   = 6'd32;
    localparam logic [5:0] LIMIT_RESET = 6'd32;

    // Address prefix bytes
    localparam logic [7:0] V4_LL_B0      = 8'd169;
    localparam logic [7:0] V4_LL_B1      = 8'd254;
    localparam logic [7:0] V4_MC_MASK    = 8'hf0;
    localparam logic [7:0] V4_MC_B0      = 8'd224;
    localparam logic [7:0] V4_NET10      = 8'd10;
    localparam logic [7:0] V4_CGN        = 8'd100;
    localparam logic [7:0] V4_LOOP       = 8'd127;
    localparam logic [7:0] V4_P172_B0    = 8'd172;
    localparam logic [7:0] V4_P172_LO    = 8'd16;
    localparam logic [7:0] V4_P172_HI    = 8'd31;
    localparam logic [7:0] V4_P192_B0    = 8'd192;
    localparam logic [7:0] V4_P192_B1    = 8'd168;
    localparam logic [7:0] V6_LL_B0      = 8'hfe;
    localparam logic [7:0] V6_LL_MASK    = 8'hc0;
    localparam logic [7:0] V6_LL_B1      = 8'h80;
    localparam logic [7:0] V6_MC_B0      = 8'hff;
    localparam logic [7:0] V6_ULA_MASK   = 8'hfe;
    localparam logic [7:0] V6_ULA_B0     = 8'hfc;

    typedef enum logic [4:0] {
        S_LOAD  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_PICK  = 5'b00100,
        S_FETCH = 5'b01000,
        S_FLUSH = 5'b10000
    } t_state;

    typedef struct packed {
        logic [63:0] upper;
        logic [63:0] lower;
        logic [31:0] iface;
        logic [2:0]  rank;
    } t_entry;

endpackage

[sv/local_address_candidate_ranker_top.sv]
// Collects interface address records (one per input word, one cycle each) into a
// MAX_ENTRIES-deep record memory, dropping filtered ones, then on the word with
// tlast set emits up to result_limit candidates, best rank first, earliest record
// on ties, one per interface before the rest. Each candidate costs one scan of the
// record memory through its single read port. The pass change costs one more scan,
// as does the end of a run that stops short of its limit.
// One run is handled at a time; input is taken again once the last candidate sits
// in the output register. A run with nothing to offer emits a single word with
// tuser set.
module local_address_candidate_ranker_top #(
    parameter int MAX_ENTRIES = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // APB configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lacr_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [lacr_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [lacr_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    // record input
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // addr_upper, addr_lower, iface_index, iface_up_running, iface_loopback, addr_flags
    input  logic [lacr_pkg::IN_DATA_W-1:0]    s_tdata,
    // addr_kind
    input  logic [lacr_pkg::IN_USER_W-1:0]    s_tuser,
    input  logic                              s_tlast,
    // candidate output
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // cand_upper, cand_lower, cand_port, cand_scope
    output logic [lacr_pkg::OUT_DATA_W-1:0]   m_tdata,
    // none_found
    output logic [lacr_pkg::OUT_USER_W-1:0]   m_tuser,
    output logic                              m_tlast
);
    import lacr_pkg::*;

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    // configuration
    logic        r_family;
    logic [15:0] r_port;
    logic [5:0]  r_limit;
    logic [31:0] r_only;

    // control
    t_state                 r_state,   n_state;
    logic [CNT_W-1:0]       r_count,   n_count;
    logic [CNT_W-1:0]       r_issue,   n_issue;
    logic                   r_chk,     n_chk;
    logic [IDX_W-1:0]       r_chk_idx, n_chk_idx;
    logic                   r_best_v,  n_best_v;
    logic [IDX_W-1:0]       r_best,    n_best;
    logic [2:0]             r_best_rank, n_best_rank;
    logic                   r_pass,    n_pass;
    logic [5:0]             r_made,    n_made;
    logic [MAX_ENTRIES-1:0] r_taken,   n_taken;
    logic [MAX_ENTRIES-1:0] r_blocked, n_blocked;
    logic                   r_pend_v,  n_pend_v;
    logic                   r_ovalid,  n_ovalid;

    // payload
    t_entry                 r_rd;
    t_entry                 r_pend;
    logic [OUT_DATA_W-1:0]  r_odata;
    logic                   r_ouser;
    logic                   r_olast;

    t_entry mem [MAX_ENTRIES];

    logic             cfg_we;
    logic [1:0]       cfg_idx;

    logic             in_acc;
    logic [63:0]      in_up, in_lo, up_m, lo_m;
    logic [31:0]      in_ifc, in_flags;
    logic             in_upr, in_lpb, is_v4;
    logic [7:0]       b0, b1;
    logic [1:0]       want_kind;
    logic             v4_priv, drop_addr, keep;
    logic [2:0]       in_rank;
    t_entry           wr_entry;
    logic             mem_we;

    logic [5:0]       lim;
    logic             chk_blk, chk_elig, chk_better;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             pend_load;
    logic             out_free, out_load;
    logic [OUT_DATA_W-1:0] out_data;
    logic             out_user, out_last;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_we  = psel && penable && pwrite && pready;

    always_comb begin
        case (cfg_idx)
            REG_FAMILY: prdata = {31'h0, r_family};
            REG_PORT:   prdata = {16'h0, r_port};
            REG_LIMIT:  prdata = {26'h0, r_limit};
            REG_ONLY:   prdata = r_only;
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_family <= 1'b0;
            r_port   <= '0;
            r_limit  <= LIMIT_RESET;
            r_only   <= '0;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_FAMILY: r_family <= pwdata[0];
                REG_PORT:   r_port   <= pwdata[15:0];
                REG_LIMIT:  r_limit  <= pwdata[5:0];
                REG_ONLY:   r_only   <= pwdata;
                default:    ;
            endcase
        end
    end

    // ---------------- record filter and rank ----------------
    assign in_up    = s_tdata[63:0];
    assign in_lo    = s_tdata[127:64];
    assign in_ifc   = s_tdata[159:128];
    assign in_upr   = s_tdata[160];
    assign in_lpb   = s_tdata[161];
    assign in_flags = s_tdata[193:162];

    assign is_v4     = (s_tuser == KIND_V4);
    // IPv4 keeps only the top 32 bits
    assign up_m      = is_v4 ? {in_up[63:32], 32'h0} : in_up;
    assign lo_m      = is_v4 ? 64'h0 : in_lo;
    assign b0        = up_m[63:56];
    assign b1        = up_m[55:48];
    assign want_kind = r_family ? KIND_V6 : KIND_V4;

    assign v4_priv = (b0 == V4_NET10) || (b0 == V4_CGN) || (b0 == V4_LOOP) ||
                     ((b0 == V4_P172_B0) && (b1 >= V4_P172_LO) && (b1 <= V4_P172_HI)) ||
                     ((b0 == V4_P192_B0) && (b1 == V4_P192_B1));

    always_comb begin
        if (is_v4) begin
            drop_addr = ((b0 == V4_LL_B0) && (b1 == V4_LL_B1)) ||
                        ((b0 & V4_MC_MASK) == V4_MC_B0);
            in_rank   = v4_priv ? RANK_PRIVATE : RANK_PUBLIC;
        end else begin
            drop_addr = ((b0 == V6_LL_B0) && ((b1 & V6_LL_MASK) == V6_LL_B1)) ||
                        (b0 == V6_MC_B0);
            in_rank   = (((b0 & V6_ULA_MASK) == V6_ULA_B0) ? RANK_ULA : RANK_PUBLIC)
                        + {2'b0, |(in_flags & FLAG_TEMPORARY)};
        end
        if (|(in_flags & FLAG_BAD)) begin
            in_rank = RANK_NONE;
        end
    end

    assign keep = (s_tuser == want_kind) && in_upr && !in_lpb &&
                  ((r_only == 32'h0) || (r_only == in_ifc)) &&
                  !((up_m == 64'h0) && (lo_m == 64'h0)) && !drop_addr;

    assign in_acc   = s_tvalid && s_tready;
    assign s_tready = (r_state == S_LOAD);
    assign mem_we   = in_acc && keep && (r_count < CNT_W'(MAX_ENTRIES));
    assign wr_entry = '{upper: up_m, lower: lo_m, iface: in_ifc, rank: in_rank};

    // ---------------- record memory ----------------
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_count[IDX_W-1:0]] <= wr_entry;
        end
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    // ---------------- selection ----------------
    assign lim = (r_limit > LIMIT_MAX) ? LIMIT_MAX : r_limit;

    // pass 0: an entry is blocked once a pick shares its interface; r_pend is the
    // latest pick, folded in while the next scan walks past each entry
    assign chk_blk    = r_blocked[r_chk_idx] || (r_pend_v && (r_rd.iface == r_pend.iface));
    assign chk_elig   = !r_taken[r_chk_idx] && (r_rd.rank != RANK_NONE) && (r_pass || !chk_blk);
    assign chk_better = chk_elig && (!r_best_v || (r_rd.rank < r_best_rank));

    assign out_free = !r_ovalid || m_tready;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_issue     = r_issue;
        n_chk       = 1'b0;
        n_chk_idx   = r_chk_idx;
        n_best_v    = r_best_v;
        n_best      = r_best;
        n_best_rank = r_best_rank;
        n_pass      = r_pass;
        n_made      = r_made;
        n_taken     = r_taken;
        n_blocked   = r_blocked;
        n_pend_v    = r_pend_v;
        rd_en       = 1'b0;
        rd_addr     = r_issue[IDX_W-1:0];
        pend_load   = 1'b0;
        out_load    = 1'b0;
        out_data    = {r_pend.iface, r_port, r_pend.lower, r_pend.upper};
        out_user    = 1'b0;
        out_last    = 1'b0;

        case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    if (mem_we) begin
                        n_count = r_count + 1'b1;
                    end
                    if (s_tlast) begin
                        n_pass   = 1'b0;
                        n_made   = '0;
                        n_issue  = '0;
                        n_best_v = 1'b0;
                        n_state  = (lim == 6'd0) ? S_FLUSH : S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_issue < r_count) begin
                    rd_en     = 1'b1;
                    n_chk     = 1'b1;
                    n_chk_idx = r_issue[IDX_W-1:0];
                    n_issue   = r_issue + 1'b1;
                end
                if (r_chk) begin
                    if (!r_pass) begin
                        n_blocked[r_chk_idx] = chk_blk;
                    end
                    if (chk_better) begin
                        n_best_v    = 1'b1;
                        n_best      = r_chk_idx;
                        n_best_rank = r_rd.rank;
                    end
                end else if (r_issue >= r_count) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                if (r_best_v) begin
                    n_taken[r_best] = 1'b1;
                    rd_en   = 1'b1;
                    rd_addr = r_best;
                    n_state = S_FETCH;
                end else if (!r_pass) begin
                    n_pass   = 1'b1;
                    n_issue  = '0;
                    n_state  = S_SCAN;
                end else begin
                    n_state = S_FLUSH;
                end
            end
            S_FETCH: begin
                // the previous pick goes out once we know another follows it
                if (!r_pend_v || out_free) begin
                    out_load  = r_pend_v;
                    pend_load = 1'b1;
                    n_pend_v  = 1'b1;
                    n_made    = r_made + 1'b1;
                    n_issue   = '0;
                    n_best_v  = 1'b0;
                    n_state   = ((r_made + 1'b1) >= lim) ? S_FLUSH : S_SCAN;
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (r_pend_v) begin
                        out_last = 1'b1;
                    end else begin
                        out_data = '0;
                        out_user = 1'b1;
                    end
                    n_pend_v  = 1'b0;
                    n_count   = '0;
                    n_taken   = '0;
                    n_blocked = '0;
                    n_state   = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    assign n_ovalid = out_load ? 1'b1 : (m_tready ? 1'b0 : r_ovalid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_issue     <= '0;
            r_chk       <= 1'b0;
            r_chk_idx   <= '0;
            r_best_v    <= 1'b0;
            r_best      <= '0;
            r_best_rank <= '0;
            r_pass      <= 1'b0;
            r_made      <= '0;
            r_taken     <= '0;
            r_blocked   <= '0;
            r_pend_v    <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_issue     <= n_issue;
            r_chk       <= n_chk;
            r_chk_idx   <= n_chk_idx;
            r_best_v    <= n_best_v;
            r_best      <= n_best;
            r_best_rank <= n_best_rank;
            r_pass      <= n_pass;
            r_made      <= n_made;
            r_taken     <= n_taken;
            r_blocked   <= n_blocked;
            r_pend_v    <= n_pend_v;
            r_ovalid    <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pend_load) begin
            r_pend <= r_rd;
        end
        if (out_load) begin
            r_odata <= out_data;
            r_ouser <= out_user;
            r_olast <= out_last;
        end
    end

    assign m_tvalid = r_ovalid;
    assign m_tdata  = r_odata;
    assign m_tuser  = r_ouser;
    assign m_tlast  = r_olast;

    // ---------------- assertions ----------------
    a_taken_matches_made: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> ($countones(r_taken) == r_made))
        else $error("taken bits out of step with emitted count");

    a_made_within_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> (r_made <= lim))
        else $error("more candidates than the limit");

    a_fetch_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FETCH) |-> (r_best_v && (r_best < r_count)))
        else $error("fetching a record outside the stored range");

    a_empty_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> !(m_tlast && m_tuser[0]))
        else $error("empty result marked as last candidate");

    a_pend_after_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FETCH) && $past(r_state == S_PICK) |=> r_pend_v || (r_state == S_FETCH))
        else $error("pick not captured");

endmodule

[verif/local_address_candidate_ranker_top_tb.sv]
`timescale 1ns / 1ps

module local_address_candidate_ranker_top_tb;

    localparam int MAX_ENTRIES  = 32;
    localparam int SETTLE       = MAX_ENTRIES + 16;
    localparam int RANDOM_ITEMS = 206;
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_BAD  = 2'd3;

    localparam logic [31:0] FLG_TEMP = 32'h0000_0001;
    localparam logic [31:0] FLG_DAD  = 32'h0000_0008;
    localparam logic [31:0] FLG_DEPR = 32'h0000_0020;
    localparam logic [31:0] FLG_TENT = 32'h0000_0040;
    localparam logic [31:0] FLG_UNUSABLE = FLG_DAD | FLG_DEPR | FLG_TENT;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] up;
        logic [63:0] lo;
        logic [31:0] ifc;
        logic        upr;
        logic        loop;
        logic [31:0] flags;
        logic        last;
    } t_rec;

    typedef struct packed {
        logic [63:0] up;
        logic [63:0] lo;
        logic [15:0] port;
        logic [31:0] scope;
        logic        empty;
        logic        fin;
    } t_res;

    typedef struct packed {
        bit          is_cfg;
        logic [1:0]  reg_idx;
        logic [31:0] reg_val;
        t_rec        rec;
        bit          typed;
        t_res        want;
    } t_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel    = 1'b0;
    logic penable = 1'b0;
    logic pwrite  = 1'b0;
    logic [lacr_pkg::APB_ADDR_W-1:0] paddr  = '0;
    logic [lacr_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [lacr_pkg::APB_DATA_W-1:0] prdata;
    logic pready;
    logic s_tvalid = 1'b0;
    logic s_tready;
    // addr_upper, addr_lower, iface_index, iface_up_running, iface_loopback, addr_flags
    logic [lacr_pkg::IN_DATA_W-1:0] s_tdata = '0;
    // addr_kind
    logic [lacr_pkg::IN_USER_W-1:0] s_tuser = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    // cand_upper, cand_lower, cand_port, cand_scope
    logic [lacr_pkg::OUT_DATA_W-1:0] m_tdata;
    // none_found
    logic [lacr_pkg::OUT_USER_W-1:0] m_tuser;
    logic m_tlast;

    local_address_candidate_ranker_top #(.MAX_ENTRIES(MAX_ENTRIES)) dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    logic        cfg_family;
    logic [15:0] cfg_port;
    logic [5:0]  cfg_limit;
    logic [31:0] cfg_only;
    logic [63:0] st_upper [MAX_ENTRIES];
    logic [63:0] st_lower [MAX_ENTRIES];
    logic [31:0] st_iface [MAX_ENTRIES];
    logic [2:0]  st_rank  [MAX_ENTRIES];
    bit          st_taken [MAX_ENTRIES];
    int          st_count;

    t_res ranked [MAX_ENTRIES];
    t_res pending_cands [$];
    t_row dir_rows [$];
    int   errors = 0;
    int   cycles = 0;
    bit   calm   = 1'b0;
    int   rdy_hold = 0;

    function automatic void absorb_record(input t_rec r);
        logic [63:0] up;
        logic [63:0] lo;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [2:0]  rank;
        bit          v4;
        if (r.kind != {1'b0, cfg_family} + 2'd1) return;
        if (!r.upr || r.loop) return;
        if (cfg_only != 32'd0 && cfg_only != r.ifc) return;
        v4 = (r.kind == lacr_pkg::KIND_V4);
        up = r.up;
        lo = r.lo;
        if (v4) begin
            up[31:0] = 32'd0;
            lo = 64'd0;
        end
        b0 = up[63:56];
        b1 = up[55:48];
        if (up == 64'd0 && lo == 64'd0) return;
        if (v4) begin
            if (b0 == 8'd169 && b1 == 8'd254) return;
            if ((b0 & 8'hf0) == 8'd224) return;
            rank = (b0 == 8'd10 || b0 == 8'd100 || b0 == 8'd127 ||
                    (b0 == 8'd172 && b1 >= 8'd16 && b1 <= 8'd31) ||
                    (b0 == 8'd192 && b1 == 8'd168)) ?
                   lacr_pkg::RANK_PRIVATE : lacr_pkg::RANK_PUBLIC;
        end else begin
            if (b0 == 8'hfe && (b1 & 8'hc0) == 8'h80) return;
            if (b0 == 8'hff) return;
            rank = ((b0 & 8'hfe) == 8'hfc) ? lacr_pkg::RANK_ULA : lacr_pkg::RANK_PUBLIC;
            if ((r.flags & FLG_TEMP) != 0) rank = rank + 3'd1;
        end
        if ((r.flags & FLG_UNUSABLE) != 0) rank = lacr_pkg::RANK_NONE;
        if (st_count >= MAX_ENTRIES) return;
        st_upper[st_count] = up;
        st_lower[st_count] = lo;
        st_iface[st_count] = r.ifc;
        st_rank[st_count]  = rank;
        st_taken[st_count] = 1'b0;
        st_count++;
    endfunction

    // Fills ranked[] with the candidates of a finished run, clears the store.
    function automatic int rank_candidates();
        int lim;
        int made;
        int best;
        int sweep;
        int i;
        int j;
        bit claimed;
        lim  = (cfg_limit > 6'd32) ? 32 : int'(cfg_limit);
        made = 0;
        for (sweep = 0; sweep < 2 && made < lim; sweep++) begin
            while (made < lim) begin
                best = -1;
                for (i = 0; i < st_count; i++) begin
                    if (st_taken[i] || st_rank[i] == lacr_pkg::RANK_NONE) continue;
                    claimed = 1'b0;
                    if (sweep == 0) begin
                        for (j = 0; j < st_count; j++)
                            if (st_taken[j] && st_iface[j] == st_iface[i]) claimed = 1'b1;
                    end
                    if (claimed) continue;
                    if (best < 0 || st_rank[i] < st_rank[best]) best = i;
                end
                if (best < 0) break;
                st_taken[best]    = 1'b1;
                ranked[made]       = '0;
                ranked[made].up    = st_upper[best];
                ranked[made].lo    = st_lower[best];
                ranked[made].port  = cfg_port;
                ranked[made].scope = st_iface[best];
                made++;
            end
        end
        if (made == 0) begin
            ranked[0] = '0;
            ranked[0].empty = 1'b1;
            made = 1;
        end else begin
            ranked[made-1].fin = 1'b1;
        end
        st_count = 0;
        for (i = 0; i < MAX_ENTRIES; i++) st_taken[i] = 1'b0;
        return made;
    endfunction

    function automatic t_rec make_record();
        t_rec r;
        int   cls;
        r.up   = {$urandom, $urandom};
        r.lo   = {$urandom, $urandom};
        r.ifc  = ($urandom_range(0, 9) != 0) ? 32'($urandom_range(1, 4)) : $urandom;
        if (cfg_only != 32'd0 && $urandom_range(0, 1) == 0) r.ifc = cfg_only;
        r.upr  = ($urandom_range(0, 19) != 0);
        r.loop = ($urandom_range(0, 19) == 0);
        r.last = 1'b0;
        case ($urandom_range(0, 19))
            0, 1, 2:    r.flags = FLG_TEMP;
            3:          r.flags = FLG_DAD;
            4:          r.flags = FLG_DEPR;
            5:          r.flags = FLG_TENT;
            6:          r.flags = $urandom;
            default:    r.flags = 32'd0;
        endcase
        if ($urandom_range(0, 7) == 0) r.kind = 2'($urandom_range(0, 3));
        else r.kind = cfg_family ? lacr_pkg::KIND_V6 : lacr_pkg::KIND_V4;
        if (r.kind == lacr_pkg::KIND_V4) begin
            cls = $urandom_range(0, 10);
            case (cls)
                0: r.up[63:56] = 8'd10;
                1: r.up[63:56] = 8'd100;
                2: r.up[63:56] = 8'd127;
                3: r.up[63:48] = {8'd172, 8'($urandom_range(16, 31))};
                4: r.up[63:56] = 8'd172;
                5: r.up[63:48] = {8'd192, 8'd168};
                6: r.up[63:56] = 8'd192;
                7: r.up[63:48] = {8'd169, 8'd254};
                8: r.up[63:60] = 4'he;
                9: r.up[63:32] = 32'd0;
                default: ;
            endcase
        end else if (r.kind == lacr_pkg::KIND_V6) begin
            cls = $urandom_range(0, 8);
            case (cls)
                0, 1: r.up[63:61] = 3'b001;
                2, 3: r.up[63:57] = 7'b1111_110;
                4:    r.up[63:54] = 10'b1111_1110_10;
                5:    r.up[63:54] = 10'b1111_1110_11;
                6:    r.up[63:56] = 8'hff;
                7:    begin
                    r.up = 64'd0;
                    r.lo = 64'd0;
                end
                default: ;
            endcase
        end
        return r;
    endfunction

    function automatic void add_cfg(input logic [1:0] idx, input logic [31:0] val);
        t_row row;
        row = '0;
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_rec(input logic [1:0] kind, input logic [63:0] up,
                                    input logic [63:0] lo, input logic [31:0] ifc,
                                    input logic upr, input logic loop,
                                    input logic [31:0] flags, input logic last);
        t_row row;
        row = '0;
        row.rec = '{kind: kind, up: up, lo: lo, ifc: ifc, upr: upr, loop: loop,
                    flags: flags, last: last};
        dir_rows.push_back(row);
    endfunction

    function automatic void add_typed(input logic [63:0] up, input logic [63:0] lo,
                                      input logic [15:0] port, input logic [31:0] scope,
                                      input logic empty, input logic fin);
        int k;
        k = dir_rows.size() - 1;
        dir_rows[k].typed = 1'b1;
        dir_rows[k].want  = '{up: up, lo: lo, port: port, scope: scope,
                              empty: empty, fin: fin};
    endfunction

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            lacr_pkg::REG_FAMILY: cfg_family = val[0];
            lacr_pkg::REG_PORT:   cfg_port   = val[15:0];
            lacr_pkg::REG_LIMIT:  cfg_limit  = val[5:0];
            lacr_pkg::REG_ONLY:   cfg_only   = val;
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Waits until the block has delivered everything and finished its end-of-run scan.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_cands.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic send_record(input t_rec r, input bit typed, input t_res want);
        int n;
        int i;
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, r.flags, r.loop, r.upr, r.ifc, r.lo, r.up};
        s_tuser  <= r.kind;
        s_tlast  <= r.last;
        do @(posedge i_clk); while (!s_tready);
        absorb_record(r);
        if (r.last) begin
            n = rank_candidates();
            if (typed) pending_cands.push_back(want);
            else for (i = 0; i < n; i++) pending_cands.push_back(ranked[i]);
        end
    endtask

    // receiver: ready/stall bursts, steady ready at the end
    always @(posedge i_clk) begin
        if (calm) begin
            m_tready <= 1'b1;
        end else if (rdy_hold > 0) begin
            rdy_hold <= rdy_hold - 1;
        end else if ($urandom_range(0, 2) != 0) begin
            m_tready <= 1'b1;
            rdy_hold <= $urandom_range(1, 30);
        end else begin
            m_tready <= 1'b0;
            rdy_hold <= $urandom_range(1, 12);
        end
    end

    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = '{up: m_tdata[63:0], lo: m_tdata[127:64], port: m_tdata[143:128],
                    scope: m_tdata[175:144], empty: m_tuser[0], fin: m_tlast};
            if (pending_cands.size() == 0) begin
                if (errors < 10)
                    $display("%0t: unexpected word up=%h lo=%h port=%h scope=%h none=%b last=%b",
                             $realtime, got.up, got.lo, got.port, got.scope, got.empty,
                             got.fin);
                errors++;
            end else begin
                want = pending_cands.pop_front();
                if (got.up !== want.up || got.lo !== want.lo || got.port !== want.port ||
                    got.scope !== want.scope || got.empty !== want.empty ||
                    got.fin !== want.fin) begin
                    if (errors < 10) begin
                        $display("%0t: mismatch exp up=%h lo=%h port=%h scope=%h none=%b last=%b",
                                 $realtime, want.up, want.lo, want.port, want.scope,
                                 want.empty, want.fin);
                        $display("              got up=%h lo=%h port=%h scope=%h none=%b last=%b",
                                 got.up, got.lo, got.port, got.scope, got.empty, got.fin);
                    end
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("** local_address_candidate_ranker_top: FAILED **");
            $finish;
        end
    end

    initial begin
        int   k;
        int   items;
        int   run_no;
        int   len;
        logic [31:0] lim_v;
        logic [31:0] only_v;
        t_rec r;

        cfg_family = 1'b0;
        cfg_port   = 16'd0;
        cfg_limit  = 6'd32;
        cfg_only   = 32'd0;
        st_count   = 0;
        for (k = 0; k < MAX_ENTRIES; k++) st_taken[k] = 1'b0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // wrong family only: empty result, all other fields zero
        add_rec(KIND_NONE, 64'h0a00_0001_0000_0000, 64'd0, 32'd1, 1'b1, 1'b0, 32'd0, 1'b1);
        add_typed(64'd0, 64'd0, 16'd0, 32'd0, 1'b1, 1'b0);
        add_cfg(lacr_pkg::REG_PORT, 32'h0000_ffff);
        // stray IPv4 bits are dropped, highest interface index
        add_rec(lacr_pkg::KIND_V4, 64'h0808_0808_dead_beef, 64'hffff_ffff_ffff_ffff,
                32'hffff_ffff, 1'b1, 1'b0, 32'd0, 1'b1);
        add_typed(64'h0808_0808_0000_0000, 64'd0, 16'hffff, 32'hffff_ffff, 1'b0, 1'b1);
        // IPv4 mix: private ranges, link-local, multicast, zero, down, loopback, deprecated
        add_rec(lacr_pkg::KIND_V4, 64'h0a00_0001_0000_0000, 64'd0, 32'd2, 1'b1, 1'b0,
                32'd0, 1'b0);
        add_rec(lacr_pkg::KIND_V4, 64'ha9fe_0101_0000_0000, 64'd0, 32'd2, 1'b1, 1'b0,
                32'd0, 1'b0);
        add_rec(lacr_pkg::KIND_V4, 64'he000_0005_0000_0000, 64'd0, 32'd2, 1'b1, 1'b0,
                32'd0, 1'b0);
        add_rec(lacr_pkg::KIND_V4, 64'h0000_0000_1234_5678, 64'h55aa_55aa_55aa_55aa,
                32'd2, 1'b1, 1'b0, 32'd0, 1'b0);
        add_rec(lacr_pkg::KIND_V4, 64'hac10_0001_0000_0000, 64'd0, 32'd2, 1'b1, 1'b0,
                32'd0, 1'b0);
        add_rec(lacr_pkg::KIND_V4, 64'hac20_0001_0000_0000, 64'd0, 32'd3, 1'b1, 1'b0,
                32'd0, 1'b0);
        add_rec(lacr_pkg::KIND_V4, 64'hc0a8_0101_0000_0000, 64'd0, 32'd3, 1'b1, 1'b0,
                32'd0, 1'b0);
        add_rec(lacr_pkg::KIND_V4, 64'hcb00_7101_0000_0000, 64'd0, 32'd3, 1'b0, 1'b0,
                32'd0, 1'b0);
        add_rec(lacr_pkg::KIND_V4, 64'hc633_6401_0000_0000, 64'd0, 32'd3, 1'b1, 1'b1,
                32'd0, 1'b0);
        add_rec(lacr_pkg::KIND_V4, 64'h6440_0001_0000_0000, 64'd0, 32'd4, 1'b1, 1'b0,
                FLG_DEPR, 1'b0);
        add_rec(lacr_pkg::KIND_V4, 64'h7f00_0001_0000_0000, 64'd0, 32'd4, 1'b1, 1'b0,
                32'd0, 1'b1);
        // IPv6 on one interface, limit forces the second pass
        add_cfg(lacr_pkg::REG_FAMILY, 32'd1);
        add_cfg(lacr_pkg::REG_ONLY, 32'd5);
        add_cfg(lacr_pkg::REG_LIMIT, 32'd3);
        add_rec(lacr_pkg::KIND_V6, 64'h2001_0db8_0000_0000, 64'd1, 32'd5, 1'b1, 1'b0,
                FLG_TEMP, 1'b0);
        add_rec(lacr_pkg::KIND_V6, 64'hfe80_0000_0000_0000, 64'd1, 32'd5, 1'b1, 1'b0,
                32'd0, 1'b0);
        add_rec(lacr_pkg::KIND_V6, 64'hff02_0000_0000_0000, 64'd1, 32'd5, 1'b1, 1'b0,
                32'd0, 1'b0);
        add_rec(lacr_pkg::KIND_V6, 64'hfd12_3456_789a_0001, 64'd7, 32'd5, 1'b1, 1'b0,
                32'd0, 1'b0);
        add_rec(lacr_pkg::KIND_V6, 64'hfc00_0000_0000_0000, 64'd9, 32'd5, 1'b1, 1'b0,
                FLG_TEMP, 1'b0);
        add_rec(lacr_pkg::KIND_V6, 64'h2001_0000_0000_0000, 64'd2, 32'd6, 1'b1, 1'b0,
                32'd0, 1'b0);
        add_rec(lacr_pkg::KIND_V6, 64'h2400_0000_0000_0000, 64'd3, 32'd5, 1'b1, 1'b0,
                FLG_TENT, 1'b0);
        add_rec(KIND_BAD, 64'h2400_0000_0000_0000, 64'd4, 32'd5, 1'b1, 1'b0, 32'd0, 1'b0);
        add_rec(lacr_pkg::KIND_V6, 64'd0, 64'd0, 32'd5, 1'b1, 1'b0, 32'd0, 1'b0);
        add_rec(lacr_pkg::KIND_V6, 64'h2a00_0000_0000_0000, 64'd9, 32'd5, 1'b1, 1'b0,
                32'hffff_ffff, 1'b1);
        // limit zero: only the empty word
        add_cfg(lacr_pkg::REG_LIMIT, 32'd0);
        add_rec(lacr_pkg::KIND_V6, 64'h2001_0db8_0000_0000, 64'd1, 32'd5, 1'b1, 1'b0,
                32'd0, 1'b1);
        add_typed(64'd0, 64'd0, 16'd0, 32'd0, 1'b1, 1'b0);
        add_cfg(lacr_pkg::REG_LIMIT, 32'd63);
        add_cfg(lacr_pkg::REG_ONLY, 32'd0);
        add_cfg(lacr_pkg::REG_PORT, 32'd0);
        add_cfg(lacr_pkg::REG_FAMILY, 32'd0);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].is_cfg) begin
                drain_results();
                apb_write(dir_rows[k].reg_idx, dir_rows[k].reg_val);
            end else begin
                send_record(dir_rows[k].rec, dir_rows[k].typed, dir_rows[k].want);
            end
        end

        items  = 0;
        run_no = 0;
        while (items < RANDOM_ITEMS) begin
            if (run_no == 0 || $urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 5))
                    0:       lim_v = 32'd0;
                    1:       lim_v = 32'd1;
                    2:       lim_v = 32'd32;
                    3:       lim_v = $urandom_range(33, 63);
                    default: lim_v = $urandom_range(2, 8);
                endcase
                case ($urandom_range(0, 9))
                    0:          only_v = $urandom;
                    1, 2, 3:    only_v = $urandom_range(1, 4);
                    default:    only_v = 32'd0;
                endcase
                // first run sends more records than the store is deep
                if (run_no == 0) begin
                    lim_v  = 32'd32;
                    only_v = 32'd0;
                end
                drain_results();
                apb_write(lacr_pkg::REG_FAMILY, $urandom_range(0, 1));
                apb_write(lacr_pkg::REG_PORT, $urandom);
                apb_write(lacr_pkg::REG_LIMIT, lim_v);
                apb_write(lacr_pkg::REG_ONLY, only_v);
            end else if ($urandom_range(0, 5) == 0) begin
                drain_results();
            end
            len = (run_no == 0 || $urandom_range(0, 11) == 0) ?
                  $urandom_range(38, 46) : $urandom_range(1, 10);
            for (k = 0; k < len; k++) begin
                r = make_record();
                r.last = (k == len - 1);
                send_record(r, 1'b0, '0);
                items++;
                if (items >= RANDOM_ITEMS * 85 / 100) calm = 1'b1;
            end
            run_no++;
        end

        drain_results();
        if (errors == 0 && pending_cands.size() == 0) begin
            $display("** local_address_candidate_ranker_top: PASSED **");
        end else begin
            $display("** local_address_candidate_ranker_top: FAILED **");
        end
        $finish;
    end

endmodule
